// ===== rtl/qro_pkg.sv =====
// shared constants, register indexes and the product sign table of the
// relative orientation core; no dependencies
package qro_pkg;

   localparam int COMP_BITS_DEF = 16;

   // normalization works on the sum of squares scaled into [2^60, 2^62)
   localparam int SQRT_IN_BITS = 62;
   localparam int ROOT_BITS    = SQRT_IN_BITS / 2;

   // configuration register indexes
   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_NEGATE_W = 3'd0;
   localparam csr_index_type CSR_NEGATE_X = 3'd1;
   localparam csr_index_type CSR_NEGATE_Y = 3'd2;
   localparam csr_index_type CSR_NEGATE_Z = 3'd3;

   // conj(ref) * sample: term j of output k is ref[j] * n[j ^ k], negated
   // where the mask bit {k, j} is set
   localparam logic [15:0] TERM_NEG_MASK = 16'hAC60;

   function automatic logic term_neg(input logic [1:0] k, input logic [1:0] j);
      return TERM_NEG_MASK[{k, j}];
   endfunction

endpackage

// ===== rtl/quaternion_relative_orientation_core.sv =====
// Relative orientation core: each transfer on req_ brings one orientation
// quaternion (w, x, y, z) in signed Q2.(COMP_BITS-2). The components picked
// by the negate registers (csr index 0..3, bit 0 of csr_wdata) are negated,
// the quaternion is normalized, and the first sample after reset or any
// sample with req_rearm set is kept as the reference. The rsp_ transfer
// carries conj(reference) * sample, rounded, saturated and normalized again,
// with rsp_took_reference set when that sample became the reference. Items
// are processed one at a time by a sequencer over three bit-serial units:
// a shift-add multiplier (4 squares plus 16 products plus 4 more squares),
// a two-bit-per-cycle square root (used twice) and a restoring divider
// (used eight times), plus the alignment shifts: per normalize pass the
// sum of squares is scaled one step at a time, then each numerator gets as
// many one-bit shifts before its divide when scaling up, or the denominator
// once per pass when scaling down; at 16 bits a pass scales by 14 to 30
// steps, and a zero-norm pass skips the square root and the divides.
// A finished result sits in the rsp_ register while the next item is taken;
// req_stall is low only while the sequencer is idle. csr_ready is always
// high and writes to indexes above 3 are dropped. Nothing is cleared after
// reset beyond the control flops.
module quaternion_relative_orientation_core import qro_pkg::*; #(
   parameter int COMP_BITS = COMP_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // input item channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [COMP_BITS-1:0] req_sample_w,
   input  logic [COMP_BITS-1:0] req_sample_x,
   input  logic [COMP_BITS-1:0] req_sample_y,
   input  logic [COMP_BITS-1:0] req_sample_z,
   input  logic                 req_rearm,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [COMP_BITS-1:0] rsp_rel_w,
   output logic [COMP_BITS-1:0] rsp_rel_x,
   output logic [COMP_BITS-1:0] rsp_rel_y,
   output logic [COMP_BITS-1:0] rsp_rel_z,
   output logic                 rsp_took_reference,
   // configuration write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  csr_index_type        csr_index,
   input  logic                 csr_wdata
);

   localparam int N   = COMP_BITS;
   localparam int F   = COMP_BITS - 2;
   // sum of squares, wide enough for the scaling window too
   localparam int SW  = (2 * N + 1 > SQRT_IN_BITS) ? 2 * N + 1 : SQRT_IN_BITS;
   // divide operands: 2*num + den stays below 2^DW
   localparam int DW  = N + 33;
   // signed product accumulator
   localparam int AW  = 2 * N + 2;
   // rounded product magnitude
   localparam int MW  = AW - F;
   localparam int SHW = 6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_START,
      ST_SQ_WAIT,
      ST_SCALE,
      ST_SQRT_START,
      ST_SQRT_WAIT,
      ST_DEN_SH,
      ST_NUM_LOAD,
      ST_NUM_SH,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_PASS_END,
      ST_MUL_START,
      ST_MUL_WAIT,
      ST_ROUND,
      ST_OUT_WAIT
   } state_type;

   state_type              state_ff;
   logic [3:0]             neg_cfg_ff;
   logic                   have_ref_ff;
   logic                   took_ff;
   logic                   pass_ff;      // 0: normalize sample, 1: normalize product
   logic [1:0]             idx_ff;       // component, or term within a product
   logic [1:0]             k_ff;         // product output component
   logic [N-1:0]           mag_ff [4];   // magnitudes to normalize
   logic                   sgn_ff [4];
   logic [N-1:0]           nrm_ff [4];   // normalized sample
   logic [N-1:0]           ref_ff [4];   // reference, written before first read
   logic [N-1:0]           res_ff [4];   // normalized product
   logic [SW-1:0]          s_ff;
   logic signed [7:0]      g_ff;
   logic [DW-1:0]          den_ff;
   logic [DW-1:0]          num_ff;
   logic [SHW-1:0]         sh_ff;
   logic [AW-1:0]          acc_ff;

   logic                   rsp_valid_ff;
   logic [N-1:0]           rsp_rel_ff [4];
   logic                   rsp_took_ff;

   // input side magnitude and sign after the negate registers
   logic [N-1:0]           in_raw [4];
   logic [N-1:0]           in_mag [4];
   logic                   in_sgn [4];

   // unit hookup
   logic                   mul_start, mul_done;
   logic [N-1:0]           mul_a, mul_b;
   logic [2*N-1:0]         mul_product;
   logic                   sqrt_start, sqrt_done;
   logic [ROOT_BITS-1:0]   sqrt_root;
   logic                   div_start, div_done;
   logic [DW-1:0]          div_dividend, div_divisor;
   logic [N-1:0]           div_quotient;

   logic [N-1:0]           ref_sel, nrm_sel;
   logic [N-1:0]           ref_mag, nrm_mag;
   logic                   term_minus;
   logic [N-1:0]           q_signed;

   // product rounding
   logic                   acc_neg;
   logic [AW-1:0]          acc_abs;
   logic [AW-1:0]          acc_rnd;
   logic [MW-1:0]          rnd_mag;
   logic [MW-1:0]          rnd_limit;
   logic [MW-1:0]          rnd_clip;

   assign in_raw[0] = req_sample_w;
   assign in_raw[1] = req_sample_x;
   assign in_raw[2] = req_sample_y;
   assign in_raw[3] = req_sample_z;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         in_mag[i] = in_raw[i][N-1] ? -in_raw[i] : in_raw[i];
         in_sgn[i] = in_raw[i][N-1] ^ neg_cfg_ff[i];
      end
   end

   // operand select for the shared multiplier
   assign ref_sel    = ref_ff[idx_ff];
   assign nrm_sel    = nrm_ff[idx_ff ^ k_ff];
   assign ref_mag    = ref_sel[N-1] ? -ref_sel : ref_sel;
   assign nrm_mag    = nrm_sel[N-1] ? -nrm_sel : nrm_sel;
   assign term_minus = ref_sel[N-1] ^ nrm_sel[N-1] ^ term_neg(k_ff, idx_ff);

   assign mul_start = (state_ff == ST_SQ_START) || (state_ff == ST_MUL_START);
   assign mul_a     = (state_ff == ST_SQ_START) ? mag_ff[idx_ff] : ref_mag;
   assign mul_b     = (state_ff == ST_SQ_START) ? mag_ff[idx_ff] : nrm_mag;

   assign sqrt_start = state_ff == ST_SQRT_START;

   // rounded quotient: (2*num + den) / (2*den)
   assign div_start    = state_ff == ST_DIV_START;
   assign div_dividend = {num_ff[DW-2:0], 1'b0} + den_ff;
   assign div_divisor  = {den_ff[DW-2:0], 1'b0};
   assign q_signed     = sgn_ff[idx_ff] ? -div_quotient : div_quotient;

   // round Q(2F) to QF, ties away from zero, clamp to the component range
   assign acc_neg   = acc_ff[AW-1];
   assign acc_abs   = acc_neg ? -acc_ff : acc_ff;
   assign acc_rnd   = acc_abs + (AW'(1) << (F - 1));
   assign rnd_mag   = MW'(acc_rnd >> F);
   assign rnd_limit = acc_neg ? (MW'(1) << (N - 1)) : ((MW'(1) << (N - 1)) - 1'b1);
   assign rnd_clip  = (rnd_mag > rnd_limit) ? rnd_limit : rnd_mag;

   qro_mul #(
      .WIDTH (N)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   qro_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (s_ff[SQRT_IN_BITS-1:0]),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   qro_div #(
      .QUO_BITS (N),
      .DVD_BITS (DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         neg_cfg_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_NEGATE_W: neg_cfg_ff[0] <= csr_wdata;
            CSR_NEGATE_X: neg_cfg_ff[1] <= csr_wdata;
            CSR_NEGATE_Y: neg_cfg_ff[2] <= csr_wdata;
            CSR_NEGATE_Z: neg_cfg_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_ref_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in ST_OUT_WAIT the result register is reloaded on the transfer
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_OUT_WAIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  for (int i = 0; i < 4; i++) begin
                     mag_ff[i] <= in_mag[i];
                     sgn_ff[i] <= in_sgn[i];
                  end
                  took_ff  <= !have_ref_ff || req_rearm;
                  pass_ff  <= 1'b0;
                  idx_ff   <= '0;
                  s_ff     <= '0;
                  g_ff     <= '0;
                  state_ff <= ST_SQ_START;
               end
            end
            ST_SQ_START: begin
               state_ff <= ST_SQ_WAIT;
            end
            ST_SQ_WAIT: begin
               if (mul_done) begin
                  s_ff <= s_ff + SW'(mul_product);
                  if (idx_ff == 2'd3) begin
                     state_ff <= ST_SCALE;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= ST_SQ_START;
                  end
               end
            end
            ST_SCALE: begin
               // bring the sum of squares into [2^60, 2^62)
               if (s_ff == '0) begin
                  // zero norm passes through as all zero
                  for (int i = 0; i < 4; i++) begin
                     if (pass_ff) res_ff[i] <= '0;
                     else         nrm_ff[i] <= '0;
                  end
                  state_ff <= ST_PASS_END;
               end else if ((s_ff >> SQRT_IN_BITS) != '0) begin
                  s_ff <= s_ff >> 2;
                  g_ff <= g_ff - 1'b1;
               end else if ((s_ff >> (SQRT_IN_BITS - 2)) == '0) begin
                  s_ff <= s_ff << 2;
                  g_ff <= g_ff + 1'b1;
               end else begin
                  state_ff <= ST_SQRT_START;
               end
            end
            ST_SQRT_START: begin
               state_ff <= ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
               if (sqrt_done) begin
                  den_ff   <= DW'(sqrt_root);
                  sh_ff    <= g_ff[7] ? SHW'(-g_ff) : '0;
                  idx_ff   <= '0;
                  state_ff <= ST_DEN_SH;
               end
            end
            ST_DEN_SH: begin
               // den = root * 2^-g for a scaled-down sum
               if (sh_ff != '0) begin
                  den_ff <= den_ff << 1;
                  sh_ff  <= sh_ff - 1'b1;
               end else begin
                  state_ff <= ST_NUM_LOAD;
               end
            end
            ST_NUM_LOAD: begin
               num_ff   <= DW'(mag_ff[idx_ff]) << F;
               sh_ff    <= (!g_ff[7] && g_ff != '0) ? SHW'(g_ff) : '0;
               state_ff <= ST_NUM_SH;
            end
            ST_NUM_SH: begin
               if (sh_ff != '0) begin
                  num_ff <= num_ff << 1;
                  sh_ff  <= sh_ff - 1'b1;
               end else begin
                  state_ff <= ST_DIV_START;
               end
            end
            ST_DIV_START: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (div_done) begin
                  if (pass_ff) res_ff[idx_ff] <= q_signed;
                  else         nrm_ff[idx_ff] <= q_signed;
                  if (idx_ff == 2'd3) begin
                     state_ff <= ST_PASS_END;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= ST_NUM_LOAD;
                  end
               end
            end
            ST_PASS_END: begin
               if (pass_ff) begin
                  state_ff <= ST_OUT_WAIT;
               end else begin
                  if (took_ff) begin
                     for (int i = 0; i < 4; i++) begin
                        ref_ff[i] <= nrm_ff[i];
                     end
                     have_ref_ff <= 1'b1;
                  end
                  k_ff     <= '0;
                  idx_ff   <= '0;
                  acc_ff   <= '0;
                  state_ff <= ST_MUL_START;
               end
            end
            ST_MUL_START: begin
               state_ff <= ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
               if (mul_done) begin
                  acc_ff <= term_minus ? acc_ff - AW'(mul_product)
                                       : acc_ff + AW'(mul_product);
                  if (idx_ff == 2'd3) begin
                     state_ff <= ST_ROUND;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= ST_MUL_START;
                  end
               end
            end
            ST_ROUND: begin
               // product component becomes the next normalize input
               mag_ff[k_ff] <= N'(rnd_clip);
               sgn_ff[k_ff] <= acc_neg;
               acc_ff       <= '0;
               idx_ff       <= '0;
               if (k_ff == 2'd3) begin
                  pass_ff  <= 1'b1;
                  s_ff     <= '0;
                  g_ff     <= '0;
                  state_ff <= ST_SQ_START;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= ST_MUL_START;
               end
            end
            ST_OUT_WAIT: begin
               // result register frees up on the rsp transfer
               if (!rsp_valid_ff || !rsp_stall) begin
                  for (int i = 0; i < 4; i++) begin
                     rsp_rel_ff[i] <= res_ff[i];
                  end
                  rsp_took_ff  <= took_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall          = state_ff != ST_IDLE;
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rel_w          = rsp_rel_ff[0];
   assign rsp_rel_x          = rsp_rel_ff[1];
   assign rsp_rel_y          = rsp_rel_ff[2];
   assign rsp_rel_z          = rsp_rel_ff[3];
   assign rsp_took_reference = rsp_took_ff;

endmodule

// ===== rtl/qro_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
// no package dependencies
module qro_mul #(
   parameter int WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WIDTH-1:0]     a,
   input  logic [WIDTH-1:0]     b,
   output logic                 done,
   output logic [2*WIDTH-1:0]   product
);

   localparam int CW = $clog2(WIDTH + 1);

   logic               busy_ff;
   logic               done_ff;
   logic [CW-1:0]      cnt_ff;
   logic [WIDTH-1:0]   a_ff;
   logic [2*WIDTH-1:0] prod_ff;
   logic [WIDTH:0]     partial_sum;

   // add the multiplicand when the low bit is set, then shift right
   assign partial_sum = {1'b0, prod_ff[2*WIDTH-1:WIDTH]} +
                        (prod_ff[0] ? {1'b0, a_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            a_ff    <= a;
            prod_ff <= {{WIDTH{1'b0}}, b};
         end else if (busy_ff) begin
            prod_ff <= {partial_sum, prod_ff[WIDTH-1:1]};
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

// ===== rtl/qro_sqrt.sv =====
// digit-serial integer square root, two radicand bits per cycle
// uses qro_pkg for the radicand and root widths
module qro_sqrt import qro_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [SQRT_IN_BITS-1:0] radicand,
   output logic                    done,
   output logic [ROOT_BITS-1:0]    root
);

   localparam int RW = ROOT_BITS + 3;
   localparam int CW = $clog2(ROOT_BITS + 1);

   logic                    busy_ff;
   logic                    done_ff;
   logic [CW-1:0]           cnt_ff;
   logic [SQRT_IN_BITS-1:0] v_ff;
   logic [RW-1:0]           rem_ff;
   logic [ROOT_BITS-1:0]    root_ff;
   logic [RW-1:0]           rem_shift;
   logic [RW-1:0]           trial;
   logic                    fits;

   assign rem_shift = {rem_ff[RW-3:0], v_ff[SQRT_IN_BITS-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign fits      = rem_shift >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            v_ff    <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            v_ff    <= v_ff << 2;
            rem_ff  <= fits ? rem_shift - trial : rem_shift;
            root_ff <= {root_ff[ROOT_BITS-2:0], fits};
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(ROOT_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== rtl/qro_div.sv =====
// restoring divider, one quotient bit per cycle; the quotient must fit
// in QUO_BITS; no package dependencies
module qro_div #(
   parameter int QUO_BITS = 16,
   parameter int DVD_BITS = 49
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DVD_BITS-1:0] dividend,
   input  logic [DVD_BITS-1:0] divisor,
   output logic                done,
   output logic [QUO_BITS-1:0] quotient
);

   localparam int CW = $clog2(QUO_BITS + 1);

   logic                busy_ff;
   logic                done_ff;
   logic [CW-1:0]       cnt_ff;
   logic [DVD_BITS-1:0] rem_ff;
   logic [DVD_BITS-1:0] div_ff;
   logic [QUO_BITS-1:0] q_ff;
   logic [DVD_BITS-1:0] rem_shift;
   logic                fits;

   assign rem_shift = {rem_ff[DVD_BITS-2:0], q_ff[QUO_BITS-1]};
   assign fits      = rem_shift >= div_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= dividend >> QUO_BITS;
            q_ff    <= dividend[QUO_BITS-1:0];
            div_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= fits ? rem_shift - div_ff : rem_shift;
            q_ff   <= {q_ff[QUO_BITS-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(QUO_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ===== rtl/qro_checker.sv =====
// port-level checks for the relative orientation core, bound to the top
// level; depends on qro_pkg
module qro_checker import qro_pkg::*; #(
   parameter int COMP_BITS = COMP_BITS_DEF
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [COMP_BITS-1:0] rsp_rel_w,
   input logic [COMP_BITS-1:0] rsp_rel_z,
   input logic                 rsp_took_reference
);

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one item at a time: an accepted item blocks the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while busy");

   // a new result only appears while an item was being processed
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without work in progress");

   // held result stays put while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rel_w) &&
      $stable(rsp_rel_z) && $stable(rsp_took_reference))
      else $error("stalled result changed");

endmodule

bind quaternion_relative_orientation_core qro_checker #(
   .COMP_BITS (COMP_BITS)
) u_qro_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_rel_w          (rsp_rel_w),
   .rsp_rel_z          (rsp_rel_z),
   .rsp_took_reference (rsp_took_reference)
);

// ===== verif/quaternion_relative_orientation_core_tb.sv =====
// testbench of the quaternion relative orientation core: drives sample
// transfers and negate register writes, predicts each relative quaternion
// in place and checks it; depends on qro_pkg and the core only
`timescale 1ns / 100ps

module quaternion_relative_orientation_core_tb;
   import qro_pkg::*;

   localparam int CB   = COMP_BITS_DEF;
   localparam int FB   = CB - 2;
   localparam longint CMAX = (64'sd1 <<< (CB - 1)) - 1;
   localparam longint CMIN = -(64'sd1 <<< (CB - 1));
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int DRAIN_CYCLES   = 1200;

   typedef struct packed {
      logic [CB-1:0] w, x, y, z;
      logic          took;
   } orient_type;

   logic          clock, reset;
   logic          req_valid, req_stall, req_rearm;
   logic [CB-1:0] req_sample_w, req_sample_x, req_sample_y, req_sample_z;
   logic          rsp_valid, rsp_stall, rsp_took_reference;
   logic [CB-1:0] rsp_rel_w, rsp_rel_x, rsp_rel_y, rsp_rel_z;
   logic          csr_valid, csr_ready, csr_wdata;
   csr_index_type csr_index;

   // predictor state
   logic   negate_sel [4];
   logic   ref_valid;
   longint ref_q [4];

   orient_type expected_q [$];
   int      fail_count;
   int      idle_cycles;
   int      send_idle_pct, recv_idle_pct;
   // long hold-off request from the tests, counted down by the stall process
   int      hold_len;
   logic    hold_toggle;
   logic    hold_seen;
   int      hold_off;

   quaternion_relative_orientation_core i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint clamp(longint v);
      if (v > CMAX) return CMAX;
      if (v < CMIN) return CMIN;
      return v;
   endfunction

   function automatic longint magn(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint root62(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // scale to unit length; sum of squares fits 64 bits unsigned for these widths
   task automatic unit_scale(input longint a [4], output longint o [4]);
      longint unsigned s, r, den, num, q;
      logic [64:0] acc;
      int g;
      acc = 0;
      g = 0;
      for (int i = 0; i < 4; i++) acc += 65'(magn(a[i])) * 65'(magn(a[i]));
      if (acc == 0) begin
         o = a;
         return;
      end
      while (acc >= (65'd1 << 62)) begin
         acc >>= 2;
         g--;
      end
      s = acc[63:0];
      while (s < (64'd1 << 60)) begin
         s <<= 2;
         g++;
      end
      r = root62(s);
      den = g < 0 ? r << (-g) : r;
      for (int i = 0; i < 4; i++) begin
         num = longint'(magn(a[i])) << FB;
         if (g > 0) num <<= g;
         q = (2 * num + den) / (2 * den);
         o[i] = a[i] < 0 ? -longint'(q) : longint'(q);
      end
   endtask

   function automatic longint round_q(longint p);
      longint m;
      m = (magn(p) + (64'sd1 <<< (FB - 1))) >>> FB;
      return clamp(p < 0 ? -m : m);
   endfunction

   task automatic predict_relative(input logic [CB-1:0] s [4], input logic rearm);
      longint q [4], n [4], p [4], rel [4];
      longint aw, ax, ay, az, bw, bx, by, bz;
      orient_type e;
      for (int i = 0; i < 4; i++) begin
         q[i] = longint'($signed(s[i]));
         if (negate_sel[i]) q[i] = -q[i];
      end
      unit_scale(q, n);
      for (int i = 0; i < 4; i++) n[i] = clamp(n[i]);
      e.took = 1'b0;
      if (!ref_valid || rearm) begin
         ref_q = n;
         ref_valid = 1'b1;
         e.took = 1'b1;
      end
      aw = ref_q[0]; ax = -ref_q[1]; ay = -ref_q[2]; az = -ref_q[3];
      bw = n[0]; bx = n[1]; by = n[2]; bz = n[3];
      p[0] = round_q(aw * bw - ax * bx - ay * by - az * bz);
      p[1] = round_q(aw * bx + ax * bw + ay * bz - az * by);
      p[2] = round_q(aw * by - ax * bz + ay * bw + az * bx);
      p[3] = round_q(aw * bz + ax * by - ay * bx + az * bw);
      unit_scale(p, rel);
      e.w = CB'(clamp(rel[0]));
      e.x = CB'(clamp(rel[1]));
      e.y = CB'(clamp(rel[2]));
      e.z = CB'(clamp(rel[3]));
      expected_q.push_back(e);
   endtask

   // one sample transfer; valid stays high into the next call when back to back
   task automatic send_sample(input logic [CB-1:0] w, x, y, z, input logic rearm);
      logic [CB-1:0] s [4];
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_sample_w <= w;
      req_sample_x <= x;
      req_sample_y <= y;
      req_sample_z <= z;
      req_rearm    <= rearm;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      s = '{w, x, y, z};
      predict_relative(s, rearm);
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      end_burst();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_negate(input csr_index_type idx, input logic v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (idx <= CSR_NEGATE_Z) negate_sel[idx[1:0]] = v;
   endtask

   task automatic set_negates(input logic [3:0] m);
      write_negate(CSR_NEGATE_W, m[0]);
      write_negate(CSR_NEGATE_X, m[1]);
      write_negate(CSR_NEGATE_Y, m[2]);
      write_negate(CSR_NEGATE_Z, m[3]);
   endtask

   function automatic logic [CB-1:0] rand_comp();
      case ($urandom_range(5))
         0: return CB'(CMAX);
         1: return CB'(CMIN);
         2: return '0;
         3: return CB'($urandom_range(0, 32) - 16);
         default: return CB'($urandom);
      endcase
   endfunction

   // unit-ish orientation with random noise, the common case
   task automatic send_random();
      logic [CB-1:0] w, x, y, z;
      if ($urandom_range(9) < 7) begin
         w = CB'($urandom_range(0, 2 * 16384) - 16384);
         x = CB'($urandom_range(0, 2 * 16384) - 16384);
         y = CB'($urandom_range(0, 2 * 16384) - 16384);
         z = CB'($urandom_range(0, 2 * 16384) - 16384);
      end else begin
         w = rand_comp(); x = rand_comp(); y = rand_comp(); z = rand_comp();
      end
      send_sample(w, x, y, z, $urandom_range(19) == 0);
   endtask

   task automatic test_directed();
      send_sample(16'sd16384, '0, '0, '0, 1'b0);       // first sample becomes reference
      send_sample('0, 16'sd16384, '0, '0, 1'b0);
      send_sample('0, '0, '0, '0, 1'b0);               // zero norm passes through
      send_sample(CB'(CMAX), CB'(CMAX), CB'(CMAX), CB'(CMAX), 1'b0);
      send_sample(CB'(CMIN), CB'(CMIN), CB'(CMIN), CB'(CMIN), 1'b0);
      send_sample(CB'(CMIN), '0, '0, '0, 1'b1);        // rearm on most negative
      send_sample(16'sd1, '0, '0, '0, 1'b0);           // tiny norm scaled up
      send_sample('0, '0, '0, 16'sd1, 1'b0);
      send_sample(16'sd11585, 16'sd11585, '0, '0, 1'b0);
      send_sample('0, '0, '0, '0, 1'b1);               // zero reference
      send_sample(16'sd100, 16'sd200, 16'sd300, 16'sd400, 1'b0);
      send_sample(CB'(CMAX), CB'(CMIN), CB'(CMAX), CB'(CMIN), 1'b1);
      send_sample(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 1'b0);
      wait_drained();
   endtask

   task automatic test_negates();
      // every mask incl. all clear and all set, register past the end ignored
      for (int m = 1; m <= 16; m++) begin
         set_negates(4'(m));
         write_negate(csr_index_type'(4 + m % 4), 1'b1);
         send_sample(CB'(CMIN), 16'sd5000, CB'(CMAX), 16'sd1, 1'b1);
         send_random();
         send_random();
         wait_drained();
      end
   endtask

   task automatic test_random(input int count, input int s_pct, input int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 99) begin
            wait_drained();
            set_negates(4'($urandom));
         end
         send_random();
      end
      wait_drained();
   endtask

   // receiver holds off long while the sender keeps offering items
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_len = 4000;
      hold_toggle = ~hold_toggle;
      for (int i = 0; i < 6; i++) send_random();
      wait_drained();
   endtask

   // receiver stall process with its own hold-off counter
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_off  <= 0;
         hold_seen <= hold_toggle;
      end else if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_off  <= hold_len - 1;
         rsp_stall <= 1'b1;
      end else if (hold_off > 0) begin
         hold_off  <= hold_off - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= $urandom_range(99) < recv_idle_pct;
      end
   end

   // result checker
   always @(posedge clock) begin
      orient_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result w=%h x=%h y=%h z=%h took=%b", $time,
                     rsp_rel_w, rsp_rel_x, rsp_rel_y, rsp_rel_z, rsp_took_reference);
            fail_count++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_rel_w !== e.w || rsp_rel_x !== e.x || rsp_rel_y !== e.y ||
                rsp_rel_z !== e.z || rsp_took_reference !== e.took) begin
               $display("%0t: mismatch expected w=%h x=%h y=%h z=%h took=%b", $time,
                        e.w, e.x, e.y, e.z, e.took);
               $display("%0t:          actual   w=%h x=%h y=%h z=%h took=%b", $time,
                        rsp_rel_w, rsp_rel_x, rsp_rel_y, rsp_rel_z, rsp_took_reference);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("quaternion_relative_orientation_core_tb NOT OK");
         $finish;
      end
   end

   initial begin
      hold_len = 0;
      hold_toggle = 1'b0;
      send_idle_pct = 8;
      recv_idle_pct = 79;
      ref_valid = 1'b0;
      for (int i = 0; i < 4; i++) begin
         negate_sel[i] = 1'b0;
         ref_q[i] = 0;
      end
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_w = '0;
      req_sample_x = '0;
      req_sample_y = '0;
      req_sample_z = '0;
      req_rearm = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_NEGATE_W;
      csr_wdata = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_negates();
      test_backpressure();
      test_random(400, 8, 79);
      test_random(400, 79, 8);
      test_random(350, 0, 0);
      set_negates(4'd0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_q.size() == 0)
         $display("quaternion_relative_orientation_core_tb OK");
      else
         $display("quaternion_relative_orientation_core_tb NOT OK");
      $finish;
   end

endmodule
